// ----- rtl/ptme_pkg.sv -----
`default_nettype none
package ptme_pkg;

   localparam int unsigned AddrWidth  = 48;
   localparam int unsigned SumWidth   = AddrWidth + 1;
   localparam int unsigned IndexWidth = 9;
   localparam int unsigned PageShift  = 12;
   localparam int unsigned KeyWidth   = AddrWidth - PageShift;
   localparam int unsigned PagesWidth = 21;

   localparam logic [63:0] ADDR_MASK   = 64'h0000_FFFF_FFFF_F000;
   localparam logic [63:0] D_VALID     = 64'h1;
   localparam logic [63:0] D_TABLE     = 64'h2;
   localparam logic [63:0] D_AP_UNPRIV = 64'h40;
   localparam logic [63:0] D_AF        = 64'h400;
   localparam logic [63:0] D_SH_INNER  = 64'h300;
   localparam logic [63:0] D_NG        = 64'h800;

   localparam logic [5:0] VA_WIDTH_MIN = 6'd39;
   localparam logic [5:0] VA_WIDTH_MAX = 6'd48;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BADARG  = 3'd1,
      ST_RANGE   = 3'd2,
      ST_FULL    = 3'd3,
      ST_BLOCK   = 3'd4,
      ST_NOTPOOL = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      OP_MAP  = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_VA_WIDTH  = 1'b0,
      CSR_POOL_BASE = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [3:0] {
      S_BOOT,
      S_IDLE,
      S_RANGE,
      S_RD,
      S_EVAL,
      S_CLR,
      S_LINK,
      S_LOOKUP,
      S_LEAF,
      S_NEXT_VA,
      S_NEXT_PA,
      S_GET,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [5:0]           va_width;
      logic [AddrWidth-1:0] pool_base;
   } cfg_type;

   typedef struct packed {
      alu_op_type          op;
      logic [SumWidth-1:0] a;
      logic [SumWidth-1:0] b;
   } alu_req_type;

   function automatic logic [IndexWidth-1:0] level_index(input logic [AddrWidth-1:0] va,
                                                         input logic [1:0] level);
      logic [IndexWidth-1:0] idx;
      unique case (level)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/page_table_map_engine_unit.sv -----
`default_nettype none
// Read request: the entry is read on acceptance, checked in S_GET, returned via S_DONE; a
// rejected map request passes S_RANGE, S_DONE. Map request: per page, each level passes S_RD,
// S_EVAL, then S_LOOKUP, or S_CLR (512 entries) and S_LINK for a new table; S_LEAF writes
// the leaf, and S_NEXT_VA and S_NEXT_PA advance between pages. One request at a time: new
// ones are taken only in S_IDLE; a result held back by rsp_ready delays the following result.
// After reset, S_BOOT clears the root table's 512 entries; reset is synchronous, active high.
module page_table_map_engine_unit
   import ptme_pkg::*;
#(
   parameter int unsigned POOL_TABLES = 64
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [47:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [47:0] req_io_virtual_address,
   input  wire logic [47:0] req_buffer_physical_address,
   input  wire logic [31:0] req_buffer_length_bytes,
   input  wire logic        req_privileged,
   input  wire logic [5:0]  req_read_table_number,
   input  wire logic [8:0]  req_read_entry_number,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_entry_value,
   output logic [6:0]       rsp_tables_used,
   output logic [31:0]      rsp_mappings_done
);

   cfg_type cfg_ff, cfg_in;
   alu_req_type alu_req;
   logic [SumWidth-1:0] alu_result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_VA_WIDTH:  cfg_in.va_width  = csr_wdata[5:0];
            CSR_POOL_BASE: cfg_in.pool_base = csr_wdata & ADDR_MASK[AddrWidth-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.va_width  <= VA_WIDTH_MIN;
         cfg_ff.pool_base <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptme_alu u_alu (
      .req    (alu_req),
      .result (alu_result)
   );

   ptme_walker #(.POOL_TABLES(POOL_TABLES)) u_walker (
      .clock                       (clock),
      .reset                       (reset),
      .cfg                         (cfg_ff),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_opcode                  (req_opcode),
      .req_io_virtual_address      (req_io_virtual_address),
      .req_buffer_physical_address (req_buffer_physical_address),
      .req_buffer_length_bytes     (req_buffer_length_bytes),
      .req_privileged              (req_privileged),
      .req_read_table_number       (req_read_table_number),
      .req_read_entry_number       (req_read_entry_number),
      .rsp_valid                   (rsp_valid),
      .rsp_ready                   (rsp_ready),
      .rsp_status                  (rsp_status),
      .rsp_entry_value             (rsp_entry_value),
      .rsp_tables_used             (rsp_tables_used),
      .rsp_mappings_done           (rsp_mappings_done),
      .alu_req                     (alu_req),
      .alu_result                  (alu_result)
   );

endmodule
`default_nettype wire

// ----- rtl/ptme_alu.sv -----
`default_nettype none
module ptme_alu
   import ptme_pkg::*;
(
   input  alu_req_type         req,
   output logic [SumWidth-1:0] result
);

   logic [SumWidth-1:0] operand_b;

   assign operand_b = (req.op == ALU_SUB) ? ~req.b : req.b;
   assign result    = req.a + operand_b + {{(SumWidth-1){1'b0}}, (req.op == ALU_SUB)};

endmodule
`default_nettype wire

// ----- rtl/ptme_walker.sv -----
`default_nettype none
module ptme_walker
   import ptme_pkg::*;
#(
   parameter int unsigned POOL_TABLES = 64
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_opcode,
   input  wire logic [47:0]   req_io_virtual_address,
   input  wire logic [47:0]   req_buffer_physical_address,
   input  wire logic [31:0]   req_buffer_length_bytes,
   input  wire logic          req_privileged,
   input  wire logic [5:0]    req_read_table_number,
   input  wire logic [8:0]    req_read_entry_number,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [63:0]        rsp_entry_value,
   output logic [6:0]         rsp_tables_used,
   output logic [31:0]        rsp_mappings_done,
   output alu_req_type        alu_req,
   input  wire logic [SumWidth-1:0] alu_result
);

   localparam int unsigned TW    = $clog2(POOL_TABLES);
   localparam int unsigned CW    = $clog2(POOL_TABLES + 1);
   localparam int unsigned MW    = TW + IndexWidth;
   localparam int unsigned DEPTH = POOL_TABLES * 512;
   localparam logic [KeyWidth-1:0] POOL_KEY = KeyWidth'(POOL_TABLES);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;
   logic        rd_en;
   logic [MW-1:0] rd_addr, wr_addr;
   logic        wr_en;
   logic [63:0] wr_data;

   state_type state_ff, state_in;
   logic [1:0]  level_ff, level_in;
   logic [TW-1:0] tbl_ff, tbl_in;
   logic [IndexWidth-1:0] cnt_ff, cnt_in;
   logic [AddrWidth-1:0] va_ff, va_in, pa_ff, pa_in;
   logic [31:0] len_ff, len_in;
   logic        priv_ff, priv_in;
   logic [5:0]  rt_ff, rt_in;
   logic [PagesWidth-1:0] pages_ff, pages_in;
   logic [CW-1:0] alloc_ff, alloc_in;
   logic [31:0] succ_ff, succ_in;
   status_type  res_status_ff, res_status_in;
   logic [63:0] res_entry_ff, res_entry_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_entry_ff, rsp_entry_in;
   logic [6:0]  rsp_tables_ff, rsp_tables_in;
   logic [31:0] rsp_maps_ff, rsp_maps_in;

   logic [KeyWidth-1:0] alloc_key, lookup_key, rt_key;
   logic [SumWidth-1:0] range_limit;
   logic [1:0]  start_level;
   logic [IndexWidth-1:0] cur_idx;
   logic [AddrWidth-1:0] pa_page;
   logic [5:0]  eff_width;
   logic        accept;

   assign accept     = req_valid && req_ready;
   assign alloc_key  = KeyWidth'(alloc_ff);
   assign lookup_key = alu_result[AddrWidth-1:PageShift];
   assign rt_key     = KeyWidth'(rt_ff);
   assign eff_width  = (cfg.va_width < VA_WIDTH_MIN) ? VA_WIDTH_MIN :
                       (cfg.va_width > VA_WIDTH_MAX) ? VA_WIDTH_MAX : cfg.va_width;
   assign range_limit = {{(SumWidth-1){1'b0}}, 1'b1} << eff_width;
   assign start_level = (eff_width == VA_WIDTH_MIN) ? 2'd1 : 2'd0;
   assign cur_idx    = level_index(va_ff, level_ff);
   assign pa_page    = pa_ff & ADDR_MASK[AddrWidth-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         cnt_ff       <= '0;
         alloc_ff     <= CW'(1);
         succ_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         alloc_ff     <= alloc_in;
         succ_ff      <= succ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      tbl_ff        <= tbl_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      len_ff        <= len_in;
      priv_ff       <= priv_in;
      rt_ff         <= rt_in;
      pages_ff      <= pages_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_tables_ff <= rsp_tables_in;
      rsp_maps_ff   <= rsp_maps_in;
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      tbl_in        = tbl_ff;
      cnt_in        = cnt_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      len_in        = len_ff;
      priv_in       = priv_ff;
      rt_in         = rt_ff;
      pages_in      = pages_ff;
      alloc_in      = alloc_ff;
      succ_in       = succ_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_tables_in = rsp_tables_ff;
      rsp_maps_in   = rsp_maps_ff;
      req_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = {tbl_ff, cur_idx};
      wr_en         = 1'b0;
      wr_addr       = {tbl_ff, cur_idx};
      wr_data       = '0;
      alu_req.op    = ALU_ADD;
      alu_req.a     = {1'b0, va_ff};
      alu_req.b     = {1'b0, 36'd1, 12'd0};

      unique case (state_ff)
         S_BOOT: begin
            // The root table is the only one live after reset.
            wr_en   = 1'b1;
            wr_addr = {TW'(0), cnt_ff};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = {TW'(KeyWidth'(req_read_table_number)), req_read_entry_number};
            if (accept) begin
               va_in    = req_io_virtual_address;
               pa_in    = req_buffer_physical_address;
               len_in   = req_buffer_length_bytes;
               priv_in  = req_privileged;
               rt_in    = req_read_table_number;
               pages_in = PagesWidth'(req_buffer_length_bytes[31:12]) +
                          PagesWidth'(req_buffer_length_bytes[11:0] != '0);
               if (req_opcode == OP_READ) begin
                  rd_en    = 1'b1;
                  state_in = S_GET;
               end else begin
                  state_in = S_RANGE;
               end
            end
         end
         S_GET: begin
            res_entry_in = '0;
            if (rt_key < alloc_key && rt_key < POOL_KEY) begin
               res_status_in = ST_OK;
               res_entry_in  = rd_data_ff;
            end else begin
               res_status_in = ST_NOTPOOL;
            end
            state_in = S_DONE;
         end
         S_RANGE: begin
            alu_req.b    = {{(SumWidth-PagesWidth-PageShift){1'b0}}, pages_ff, 12'd0};
            res_entry_in = '0;
            level_in     = start_level;
            tbl_in       = '0;
            if (pa_ff == '0 || len_ff == '0 || va_ff[11:0] != '0) begin
               res_status_in = ST_BADARG;
               state_in      = S_DONE;
            end else if (alu_result > range_limit) begin
               res_status_in = ST_RANGE;
               state_in      = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!rd_data_ff[0]) begin
               if (alloc_key >= POOL_KEY) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  cnt_in   = '0;
                  state_in = S_CLR;
               end
            end else if (!rd_data_ff[1]) begin
               res_status_in = ST_BLOCK;
               state_in      = S_DONE;
            end else begin
               state_in = S_LOOKUP;
            end
         end
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = {alloc_ff[TW-1:0], cnt_ff};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            alu_req.a = {1'b0, cfg.pool_base};
            alu_req.b = {1'b0, alloc_key, 12'd0};
            wr_en     = 1'b1;
            wr_data   = ({16'd0, alu_result[AddrWidth-1:0]} & ADDR_MASK) | D_VALID | D_TABLE;
            alloc_in  = alloc_ff + 1'b1;
            tbl_in    = alloc_ff[TW-1:0];
            level_in  = level_ff + 1'b1;
            state_in  = (level_ff == 2'd2) ? S_LEAF : S_RD;
         end
         S_LOOKUP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, rd_data_ff[AddrWidth-1:0] & ADDR_MASK[AddrWidth-1:0]};
            alu_req.b  = {1'b0, cfg.pool_base};
            if (lookup_key < alloc_key) begin
               tbl_in   = lookup_key[TW-1:0];
               level_in = level_ff + 1'b1;
               state_in = (level_ff == 2'd2) ? S_LEAF : S_RD;
            end else begin
               res_status_in = ST_NOTPOOL;
               state_in      = S_DONE;
            end
         end
         S_LEAF: begin
            wr_en    = 1'b1;
            wr_data  = {16'd0, pa_page} | D_VALID | D_TABLE |
                       (priv_ff ? 64'd0 : D_AP_UNPRIV) | D_AF | D_SH_INNER | D_NG;
            pages_in = pages_ff - 1'b1;
            if (pages_ff == PagesWidth'(1)) begin
               res_status_in = ST_OK;
               if (succ_ff != '1) begin
                  succ_in = succ_ff + 1'b1;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_NEXT_VA;
            end
         end
         S_NEXT_VA: begin
            va_in    = alu_result[AddrWidth-1:0];
            state_in = S_NEXT_PA;
         end
         S_NEXT_PA: begin
            alu_req.a = {1'b0, pa_ff};
            pa_in     = alu_result[AddrWidth-1:0];
            level_in  = start_level;
            tbl_in    = '0;
            state_in  = S_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_tables_in = alloc_key[6:0];
               rsp_maps_in   = succ_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_value   = rsp_entry_ff;
   assign rsp_tables_used   = rsp_tables_ff;
   assign rsp_mappings_done = rsp_maps_ff;

`ifndef NO_ASSERTIONS
   a_alloc_bounds: assert property (@(posedge clock) disable iff (reset)
      alloc_key >= KeyWidth'(1) && alloc_key <= POOL_KEY)
      else $error("table allocation count out of bounds");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while a walk is running");
   a_alloc_only_on_link: assert property (@(posedge clock) disable iff (reset)
      (alloc_ff != $past(alloc_ff)) |-> $past(state_ff == S_LINK))
      else $error("table allocated outside the link step");
   a_result_on_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised without a finished request");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_page_table_map_engine_unit.sv -----
`default_nettype none
module tb_page_table_map_engine_unit
   import ptme_pkg::*;
;

   localparam int unsigned NUM_TABLES = 64;
   localparam int unsigned WATCHDOG_LIMIT = 200000;

   typedef struct {
      logic        opcode;
      logic [47:0] va;
      logic [47:0] pa;
      logic [31:0] len;
      logic        priv;
      logic [5:0]  table_num;
      logic [8:0]  entry_num;
   } map_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [63:0] entry;
      logic [6:0]  tables;
      logic [31:0] maps;
   } map_rsp_type;

   class page_table_scoreboard;
      logic [63:0] store [0:NUM_TABLES*512-1];
      int unsigned tables_alloc;
      logic [31:0] map_count;
      logic [5:0]  va_width;
      logic [47:0] pool_base;
      map_rsp_type pending [$];
      int unsigned errors;

      function void reset_state();
         foreach (store[i]) store[i] = '0;
         tables_alloc = 1;
         map_count = '0;
         va_width = VA_WIDTH_MIN;
         pool_base = '0;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [47:0] data);
         if (idx == CSR_VA_WIDTH) va_width = data[5:0];
         else pool_base = data & ADDR_MASK[47:0];
      endfunction

      function int unsigned width_now();
         if (va_width < VA_WIDTH_MIN) return VA_WIDTH_MIN;
         if (va_width > VA_WIDTH_MAX) return VA_WIDTH_MAX;
         return va_width;
      endfunction

      function logic [2:0] walk_page(logic [63:0] va, logic [63:0] pa, logic priv);
         int unsigned tbl, lvl, idx, k;
         logic [63:0] ent, off;
         tbl = 0;
         lvl = (width_now() == 39) ? 1 : 0;
         for (; lvl < 3; lvl++) begin
            idx = 32'((va >> (39 - lvl * 9)) & 64'h1ff);
            ent = store[tbl*512 + idx];
            if (!ent[0]) begin
               if (tables_alloc >= NUM_TABLES) return ST_FULL;
               for (int i = 0; i < 512; i++) store[tables_alloc*512 + i] = '0;
               store[tbl*512 + idx] = ((64'(pool_base) + (64'(tables_alloc) << 12)) & ADDR_MASK)
                                      | D_VALID | D_TABLE;
               tbl = tables_alloc;
               tables_alloc++;
            end else begin
               if (!ent[1]) return ST_BLOCK;
               off = ((ent & ADDR_MASK) - 64'(pool_base)) & 64'h0000_FFFF_FFFF_FFFF;
               off = off >> 12;
               if (off >= 64'(tables_alloc)) return ST_NOTPOOL;
               k = 32'(off);
               tbl = k;
            end
         end
         idx = 32'((va >> 12) & 64'h1ff);
         store[tbl*512 + idx] = (pa & ADDR_MASK) | D_VALID | D_TABLE |
                                (priv ? 64'h0 : D_AP_UNPRIV) | D_AF | D_SH_INNER | D_NG;
         return ST_OK;
      endfunction

      function logic [2:0] map_buffer(map_req_type r);
         logic [63:0] bytes, va, pa;
         logic [2:0]  st;
         va = 64'(r.va);
         pa = 64'(r.pa);
         if (pa == 0 || r.len == 0 || va[11:0] != 0) return ST_BADARG;
         bytes = (64'(r.len) + 64'd4095) & ~64'd4095;
         if (va + bytes > (64'd1 << width_now())) return ST_RANGE;
         for (logic [63:0] done = 0; done < bytes; done += 4096) begin
            st = walk_page(va + done, (pa + done) & 64'h0000_FFFF_FFFF_FFFF, r.priv);
            if (st != ST_OK) return st;
         end
         if (map_count != 32'hFFFF_FFFF) map_count++;
         return ST_OK;
      endfunction

      function void note_request(map_req_type r);
         map_rsp_type x;
         x.entry = '0;
         if (r.opcode == OP_READ) begin
            if (r.table_num < tables_alloc) begin
               x.entry = store[r.table_num*512 + r.entry_num];
               x.status = ST_OK;
            end else begin
               x.status = ST_NOTPOOL;
            end
         end else begin
            x.status = map_buffer(r);
         end
         x.tables = tables_alloc[6:0];
         x.maps = map_count;
         pending.push_back(x);
      endfunction

      function void check_response(map_rsp_type a);
         map_rsp_type x;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         x = pending.pop_front();
         if (a.status !== x.status) begin
            $error("status: expected %0d actual %0d", x.status, a.status);
            errors++;
         end
         if (a.entry !== x.entry) begin
            $error("entry_value: expected %h actual %h", x.entry, a.entry);
            errors++;
         end
         if (a.tables !== x.tables) begin
            $error("tables_used: expected %0d actual %0d", x.tables, a.tables);
            errors++;
         end
         if (a.maps !== x.maps) begin
            $error("mappings_done: expected %0d actual %0d", x.maps, a.maps);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [47:0] req_io_virtual_address = '0;
   logic [47:0] req_buffer_physical_address = '0;
   logic [31:0] req_buffer_length_bytes = '0;
   logic        req_privileged = 1'b0;
   logic [5:0]  req_read_table_number = '0;
   logic [8:0]  req_read_entry_number = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_entry_value;
   logic [6:0]  rsp_tables_used;
   logic [31:0] rsp_mappings_done;

   page_table_scoreboard sb;
   bit          no_idle;
   int unsigned quiet_cycles;
   logic [47:0] hot_va [4];

   page_table_map_engine_unit #(.POOL_TABLES(NUM_TABLES)) DUT (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("page_table_map_engine_unit test failed");
         $finish;
      end
   end

   function automatic int unsigned idle_draw();
      return no_idle ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic send_request(map_req_type r);
      int unsigned gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode = r.opcode;
      req_io_virtual_address = r.va;
      req_buffer_physical_address = r.pa;
      req_buffer_length_bytes = r.len;
      req_privileged = r.priv;
      req_read_table_number = r.table_num;
      req_read_entry_number = r.entry_num;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [47:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic map_req_type read_item(int unsigned t, int unsigned e);
      map_req_type r;
      r = '{opcode: OP_READ, va: {$urandom, $urandom}, pa: {$urandom, $urandom},
            len: $urandom, priv: $urandom_range(0, 1), table_num: t, entry_num: e};
      return r;
   endfunction

   function automatic map_req_type map_item(logic [47:0] va, logic [47:0] pa,
                                            logic [31:0] len, logic priv);
      map_req_type r;
      r = '{opcode: OP_MAP, va: va, pa: pa, len: len, priv: priv,
            table_num: $urandom, entry_num: $urandom};
      return r;
   endfunction

   function automatic map_req_type random_item();
      map_req_type r;
      logic [63:0] span, va;
      int unsigned pick;
      span = 64'd1 << sb.width_now();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         if ($urandom_range(0, 3) == 0)
            return read_item($urandom_range(0, 63), $urandom_range(0, 511));
         return read_item($urandom_range(0, sb.tables_alloc - 1), $urandom_range(0, 511));
      end
      if (pick < 80) va = 64'(hot_va[$urandom_range(0, 3)]) + (64'($urandom_range(0, 63)) << 12);
      else va = {$urandom, $urandom};
      va = va & (span - 1) & ~64'hfff;
      r = map_item(va[47:0], {$urandom, $urandom}, $urandom_range(1, 20000),
                   $urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 4) r.pa = '0;
      else if (pick < 8) r.len = '0;
      else if (pick < 12) r.va[11:0] = $urandom_range(1, 4095);
      else if (pick < 20) r.len = $urandom_range(1, 1 << 20);
      else if (pick < 26) begin
         // Huge lengths only near the top of the space, so they fail the range check.
         r.len = $urandom | 32'h8000_0000;
         va = span - (64'($urandom_range(0, 7)) << 12) - 64'h1000;
         r.va = va[47:0];
      end else if (pick < 30) begin
         r.va = {$urandom, $urandom};
         r.va[11:0] = '0;
      end
      return r;
   endfunction

   always begin : receiver
      int unsigned gap;
      map_rsp_type a;
      gap = idle_draw();
      if (gap > 0) begin
         rsp_ready = 1'b0;
         repeat (gap) @(negedge clock);
      end
      rsp_ready = 1'b1;
      do @(posedge clock); while (rsp_valid !== 1'b1);
      a = '{status: rsp_status, entry: rsp_entry_value, tables: rsp_tables_used,
            maps: rsp_mappings_done};
      sb.check_response(a);
      @(negedge clock);
   end

   initial begin
      logic [5:0]  widths [6];
      logic [47:0] bases [6];
      sb = new();
      sb.reset_state();
      foreach (hot_va[i]) hot_va[i] = {$urandom, $urandom} & 48'hFFFF_FFFF_F000;
      widths = '{6'd48, 6'd0, 6'd63, 6'd42, 6'd39, 6'd45};
      bases = '{48'h0, 48'hFFFF_FFFF_F000, 48'h0, {$urandom, $urandom}, 48'h0, 48'h0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: 39-bit space, pool at zero.
      send_request(read_item(0, 0));
      send_request(read_item(0, 511));
      send_request(read_item(63, 0));
      send_request(map_item(48'h0, 48'h0, 32'd4096, 1'b0));
      send_request(map_item(48'h0, 48'h1000, 32'd0, 1'b0));
      send_request(map_item(48'h123, 48'h1000, 32'd4096, 1'b0));
      send_request(map_item(48'h0, 48'hFFFF_FFFF_F000, 32'd8192, 1'b0));
      send_request(read_item(1, 0));
      send_request(read_item(3, 1));
      send_request(map_item(48'h7F_FFFF_F000, 48'hFFFF_FFFF_FFFF, 32'd1, 1'b1));
      send_request(map_item(48'h7F_FFFF_F000, 48'h2000, 32'd4097, 1'b1));
      send_request(map_item(48'hFFFF_FFFF_F000, 48'h2000, 32'd1, 1'b1));
      send_request(map_item(48'h7F_FFF0_0000, 48'h2000, 32'hFFFF_FFFF, 1'b0));
      send_request(map_item(48'h0, 48'h5000, 32'd4096, 1'b1));
      send_request(read_item(3, 0));
      send_request(read_item(6, 511));
      send_request(map_item(48'h40_0000_0000, 48'h7000, 32'd12288, 1'b0));
      send_request(read_item(2, 0));
      drain_block();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_VA_WIDTH, {$urandom, $urandom} & 48'hFFFF_FFFF_FFC0 | widths[ph]);
         write_csr(CSR_POOL_BASE, bases[ph] | ((ph == 3) ? 48'h0 : 48'($urandom_range(0, 4095))));
         for (int n = 0; n < 170; n++) begin
            if (n % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_request(random_item());
         end
         drain_block();
      end

      no_idle = 1'b0;
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("page_table_map_engine_unit test passed");
      else
         $display("page_table_map_engine_unit test failed");
      $finish;
   end

endmodule
`default_nettype wire
